// ===== sv/sfa_pkg.sv =====
package sfa_pkg;

    localparam int IterStages = 27;
    localparam int DivSteps   = 25;
    localparam int ExpBias    = 150;
    localparam int MaxExp     = 255;

    typedef enum logic [2:0] {
        OP_NEG, OP_ADD, OP_MUL, OP_DIV, OP_SQRT, OP_CMP, OP_I2F, OP_F2I
    } op_t;

    typedef logic signed [11:0] scale_t;

    typedef struct packed {
        op_t         op;
        logic        direct;
        logic        err;
        logic [31:0] res;
        logic        neg;
        logic [31:0] mag;
        scale_t      sh;
        logic [27:0] rem;
        logic [26:0] quot;
        logic [31:0] aux;
    } item_t;

    function automatic logic [5:0] clz32(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

    function automatic item_t iter_step(input item_t it, input logic div_on);
        item_t       o;
        logic [27:0] hi;
        logic [26:0] root;
        logic [27:0] t;
        logic [27:0] dv;
        o    = it;
        dv   = {4'b0, it.aux[23:0]};
        root = {it.quot[25:0], 1'b0};
        hi   = {it.rem[25:0], it.aux[31:30]};
        t    = {root, 1'b1};
        if (!it.direct && it.op == OP_DIV && div_on) begin
            if (it.rem >= dv) begin
                o.rem  = (it.rem - dv) << 1;
                o.quot = {it.quot[25:0], 1'b1};
            end else begin
                o.rem  = it.rem << 1;
                o.quot = {it.quot[25:0], 1'b0};
            end
        end else if (!it.direct && it.op == OP_SQRT) begin
            o.aux = {it.aux[29:0], 2'b00};
            if (hi >= t) begin
                o.rem  = hi - t;
                o.quot = root | 27'd1;
            end else begin
                o.rem  = hi;
                o.quot = root;
            end
        end
        return o;
    endfunction

endpackage

// ===== sv/soft_float_alu_core.sv =====
// An accepted input beat passes through sfa_front, sfa_iter and sfa_norm, in that order, to its result beat.
// Throughput: one beat per cycle while the output is not stalled; the 27-stage divide and square root
// array sets the depth, and every operation travels through it.
// A stalled output holds the whole pipeline and s_tready drops with it.
// Reset (aresetn low, synchronous) clears every stage valid bit.
module soft_float_alu_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // op[2:0], operand_a[34:3], operand_b[66:35],
                                  // shift_amount[74:67], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // result[31:0]
    output logic [0:0]  m_tuser   // error[0]
);
    import sfa_pkg::*;

    logic  en;
    logic  fv, iv;
    item_t fitem, iitem;
    logic  err;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    sfa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_op     (op_t'(s_tdata[2:0])),
        .in_a      (s_tdata[34:3]),
        .in_b      (s_tdata[66:35]),
        .in_shift  ($signed(s_tdata[74:67])),
        .out_valid (fv),
        .out_item  (fitem)
    );

    sfa_iter u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fv),
        .in_item   (fitem),
        .out_valid (iv),
        .out_item  (iitem)
    );

    sfa_norm u_norm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (iv),
        .in_item    (iitem),
        .out_valid  (m_tvalid),
        .out_result (m_tdata),
        .out_error  (err)
    );

    assign m_tuser = err;
endmodule

// ===== sv/sfa_front.sv =====
module sfa_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  sfa_pkg::op_t       in_op,
    input  logic [31:0]        in_a,
    input  logic [31:0]        in_b,
    input  logic signed [7:0]  in_shift,
    output logic               out_valid,
    output sfa_pkg::item_t     out_item
);
    import sfa_pkg::*;

    logic              va_reg;
    op_t               op_reg;
    logic [31:0]       a_reg;
    logic [31:0]       b_reg;
    logic signed [7:0] shift_reg;

    logic              vb_reg;
    item_t             itb_reg, itb_next;
    logic signed [24:0] opa_reg, opa_next, opb_reg, opb_next;
    logic signed [49:0] prod_reg, prod_next;

    logic              vc_reg;
    item_t             itc_reg, itc_next;

    logic [7:0]         ea, eb;
    logic [23:0]        ma, mb;
    logic signed [24:0] sva, svb;
    logic signed [9:0]  dexp, ndexp;
    logic signed [11:0] ef, nef, nexp;
    logic [31:0]        fmag;
    logic signed [31:0] ca, cb;

    always_comb begin
        ea    = a_reg[30:23];
        eb    = b_reg[30:23];
        ma    = {1'b1, a_reg[22:0]};
        mb    = {1'b1, b_reg[22:0]};
        sva   = a_reg[31] ? -$signed({1'b0, ma}) : $signed({1'b0, ma});
        svb   = b_reg[31] ? -$signed({1'b0, mb}) : $signed({1'b0, mb});
        dexp  = $signed({2'b0, ea}) - $signed({2'b0, eb});
        ndexp = -dexp;
        ef    = $signed({4'b0, ea}) - 12'sd150 - 12'(shift_reg);
        nef   = -ef;
        nexp  = $signed({4'b0, ea}) - 12'sd150;
        ca    = a_reg[31] ? -$signed({1'b0, a_reg[30:0]}) : $signed({1'b0, a_reg[30:0]});
        cb    = b_reg[31] ? -$signed({1'b0, b_reg[30:0]}) : $signed({1'b0, b_reg[30:0]});
        fmag  = '0;
        opa_next  = sva;
        opb_next  = svb;
        prod_next = sva * svb;
        itb_next  = '0;
        itb_next.op = op_reg;
        case (op_reg)
            OP_NEG: begin
                itb_next.direct = 1'b1;
                itb_next.res = (a_reg != '0) ? (a_reg ^ 32'h8000_0000) : '0;
            end
            OP_ADD: begin
                itb_next.direct = 1'b1;
                if (a_reg == '0) begin
                    itb_next.res = b_reg;
                end else if (b_reg == '0) begin
                    itb_next.res = a_reg;
                end else if (dexp > 10'sd24) begin
                    itb_next.res = a_reg;
                end else if (dexp < -10'sd24) begin
                    itb_next.res = b_reg;
                end else begin
                    itb_next.direct = 1'b0;
                    if (dexp >= 0) begin
                        opb_next = svb >>> dexp[4:0];
                        itb_next.sh = $signed({4'b0, ea}) - 12'sd150;
                    end else begin
                        opa_next = sva >>> ndexp[4:0];
                        itb_next.sh = $signed({4'b0, eb}) - 12'sd150;
                    end
                end
            end
            OP_MUL: begin
                if (a_reg == '0 || b_reg == '0) begin
                    itb_next.direct = 1'b1;
                end else begin
                    itb_next.sh = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd276;
                end
            end
            OP_DIV: begin
                if (b_reg == '0) begin
                    itb_next.direct = 1'b1;
                    itb_next.err    = 1'b1;
                end else if (a_reg == '0) begin
                    itb_next.direct = 1'b1;
                end else begin
                    itb_next.rem = {4'b0, ma};
                    itb_next.aux = {8'b0, mb};
                    itb_next.neg = a_reg[31] ^ b_reg[31];
                    itb_next.sh  = $signed({4'b0, ea}) - $signed({4'b0, eb}) - 12'sd24;
                end
            end
            OP_SQRT: begin
                if (a_reg[31]) begin
                    itb_next.direct = 1'b1;
                    itb_next.err    = 1'b1;
                end else if (a_reg == '0) begin
                    itb_next.direct = 1'b1;
                end else begin
                    itb_next.aux = nexp[0] ? {7'b0, ma, 1'b0} : {8'b0, ma};
                    itb_next.sh  = (nexp >>> 1) - 12'sd11;
                end
            end
            OP_CMP: begin
                itb_next.direct = 1'b1;
                itb_next.res = (ca > cb) ? 32'd1 : ((ca < cb) ? '1 : '0);
            end
            OP_I2F: begin
                itb_next.neg = a_reg[31];
                itb_next.mag = a_reg[31] ? (32'd0 - a_reg) : a_reg;
                itb_next.sh  = 12'(shift_reg);
            end
            default: begin
                itb_next.direct = 1'b1;
                if (ef >= 0) begin
                    fmag = (ef > 12'sd7) ? 32'h7FFF_FFFF : ({8'b0, ma} << ef[2:0]);
                end else begin
                    fmag = (nef > 12'sd23) ? '0 : ({8'b0, ma} >> nef[4:0]);
                end
                if (a_reg == '0) begin
                    itb_next.res = '0;
                end else begin
                    itb_next.res = a_reg[31] ? (32'd0 - fmag) : fmag;
                end
            end
        endcase
    end

    logic signed [25:0] sum;
    logic signed [49:0] rnd;
    logic signed [25:0] rq;

    always_comb begin
        itc_next = itb_reg;
        sum = 26'(opa_reg) + 26'(opb_reg);
        rnd = prod_reg + 50'sd8388608;
        rq  = rnd[49:24];
        if (!itb_reg.direct && itb_reg.op == OP_ADD) begin
            itc_next.neg = sum[25];
            itc_next.mag = 32'(sum[25] ? -sum : sum);
        end else if (!itb_reg.direct && itb_reg.op == OP_MUL) begin
            itc_next.neg = rq[25];
            itc_next.mag = 32'(rq[25] ? -rq : rq);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg    <= in_op;
            a_reg     <= in_a;
            b_reg     <= in_b;
            shift_reg <= in_shift;
            itb_reg   <= itb_next;
            opa_reg   <= opa_next;
            opb_reg   <= opb_next;
            prod_reg  <= prod_next;
            itc_reg   <= itc_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_item  = itc_reg;
endmodule

// ===== sv/sfa_iter.sv =====
module sfa_iter (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  sfa_pkg::item_t in_item,
    output logic           out_valid,
    output sfa_pkg::item_t out_item
);
    import sfa_pkg::*;

    item_t stage_reg  [IterStages];
    item_t stage_next [IterStages];
    logic  valid_reg  [IterStages];

    for (genvar k = 0; k < IterStages; k++) begin : g_step
        if (k == 0) begin : g_first
            always_comb begin
                stage_next[k] = iter_step(in_item, 1'b1);
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= in_valid;
                end
            end
        end else begin : g_rest
            always_comb begin
                stage_next[k] = iter_step(stage_reg[k-1], (k < DivSteps) ? 1'b1 : 1'b0);
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_valid = valid_reg[IterStages-1];
    assign out_item  = stage_reg[IterStages-1];
endmodule

// ===== sv/sfa_norm.sv =====
module sfa_norm (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  sfa_pkg::item_t in_item,
    output logic           out_valid,
    output logic [31:0]    out_result,
    output logic           out_error
);
    import sfa_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    logic        dir1_reg, err1_reg, neg1_reg;
    logic [31:0] res1_reg, mag1_reg, mag1_next;
    scale_t      sh1_reg;
    logic [5:0]  lz1_reg;

    logic        dir2_reg, err2_reg, neg2_reg, zero2_reg;
    logic [31:0] res2_reg;
    logic [23:0] mant2_reg, mant2_next;
    scale_t      exp2_reg, exp2_next;

    logic [31:0] res3_reg, res3_next;
    logic        err3_reg;

    logic [5:0]  rs, ls;
    logic [31:0] shifted;

    always_comb begin
        mag1_next = in_item.mag;
        if (!in_item.direct && (in_item.op == OP_DIV || in_item.op == OP_SQRT)) begin
            mag1_next = {5'b0, in_item.quot};
        end
    end

    always_comb begin
        rs = 6'd8 - lz1_reg;
        ls = lz1_reg - 6'd8;
        shifted = (lz1_reg < 6'd8) ? (mag1_reg >> rs) : (mag1_reg << ls);
        mant2_next = shifted[23:0];
        exp2_next = sh1_reg + 12'sd158 - $signed({6'b0, lz1_reg});
    end

    always_comb begin
        if (dir2_reg || zero2_reg || exp2_reg < 0) begin
            res3_next = dir2_reg ? res2_reg : '0;
        end else if (exp2_reg > 12'(MaxExp)) begin
            res3_next = {neg2_reg, 8'hFF, 23'h7F_FFFF};
        end else begin
            res3_next = {neg2_reg, exp2_reg[7:0], mant2_reg[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dir1_reg  <= in_item.direct;
            err1_reg  <= in_item.err;
            neg1_reg  <= in_item.neg;
            res1_reg  <= in_item.res;
            sh1_reg   <= in_item.sh;
            mag1_reg  <= mag1_next;
            lz1_reg   <= clz32(mag1_next);
            dir2_reg  <= dir1_reg;
            err2_reg  <= err1_reg;
            neg2_reg  <= neg1_reg;
            res2_reg  <= res1_reg;
            zero2_reg <= (mag1_reg == '0);
            mant2_reg <= mant2_next;
            exp2_reg  <= exp2_next;
            res3_reg  <= res3_next;
            err3_reg  <= err2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign out_result = res3_reg;
    assign out_error  = err3_reg;
endmodule

// ===== sv/sfa_checker.sv =====
module sfa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Output beat changed while stalled.");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("Error beat carries a nonzero result.");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("Input taken while the pipeline is held.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");
endmodule

bind soft_float_alu_core sfa_checker u_sfa_checker (.*);
